FILE: rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes, types and helper functions for the block pool
// allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W     = 48;
    localparam int MAX_BLOCKS = 256;
    localparam int ALIGNMENT  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int REQ_W      = 17;
    localparam int BS_W       = REQ_W + 1;
    localparam int SPAN_W     = BS_W + CNT_W;
    localparam int REM_W      = SPAN_W;
    localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int ST_W       = 3;

    localparam logic [ADDR_W-1:0] BASE_RST  = ADDR_W'(65536);
    localparam logic [REQ_W-1:0]  BSIZE_RST = REQ_W'(16);
    localparam logic [CNT_W-1:0]  NBLK_RST  = CNT_W'(256);

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FOREIGN  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_NULL     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_BSIZE = 2'd1,
        CFG_NBLK  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_DIV,
        S_FIN
    } fsm_t;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } stack_req_t;

    // block size rounded up to the alignment, zero counts as one
    function automatic logic [BS_W-1:0] eff_bsize(input logic [REQ_W-1:0] req);
        logic [BS_W-1:0] r;
        r = (req == '0) ? BS_W'(1) : {1'b0, req};
        r = r + BS_W'(ALIGNMENT - 1);
        return r & ~BS_W'(ALIGNMENT - 1);
    endfunction

    // capacity clamped to one .. MAX_BLOCKS
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] c;
        c = n;
        if (n == '0)
            c = CNT_W'(1);
        else if (n > CNT_W'(MAX_BLOCKS))
            c = CNT_W'(MAX_BLOCKS);
        return c;
    endfunction

endpackage

FILE: rtl/fbpa_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_stack
// Free index stack storage with registered read. A per-entry valid bit
// makes an unwritten entry read as its own index, so a reload clears the valid bits only.
// ----------------------------------------------------------------------------
module fbpa_stack
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  fbpa_pkg::stack_req_t     req,
    output logic [fbpa_pkg::IDX_W-1:0] rd_value
);
    import fbpa_pkg::*;

    logic [IDX_W-1:0]      mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [IDX_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic                  hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
            hit_reg     <= valid_reg[req.rd_addr];
        end
    end

    assign rd_value = hit_reg ? rd_data_reg : rd_addr_reg;

endmodule

FILE: rtl/fbpa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_divider
// Restoring divider, one quotient bit per cycle. The quotient is known to
// stay below MAX_BLOCKS, so IDX_W steps cover it.
// ----------------------------------------------------------------------------
module fbpa_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fbpa_pkg::REM_W-1:0]  dividend,
    input  logic [fbpa_pkg::BS_W-1:0]   divisor,
    output logic                        done,
    output logic [fbpa_pkg::IDX_W-1:0]  quotient,
    output logic                        exact
);
    import fbpa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  dsr_reg;
    logic [IDX_W-1:0]  q_reg;
    logic [IDX_W-1:0]  q_next;
    logic [REM_W:0]    diff;

    always_comb
    begin
        diff = {1'b0, rem_reg} - {1'b0, dsr_reg};
        if (!diff[REM_W])
        begin
            rem_next = diff[REM_W-1:0];
            q_next   = IDX_W'({q_reg, 1'b1});
        end
        else
        begin
            rem_next = rem_reg;
            q_next   = IDX_W'({q_reg, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(IDX_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsr_reg <= REM_W'({divisor, {(IDX_W - 1){1'b0}}});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dsr_reg <= dsr_reg >> 1;
            q_reg   <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign exact    = (rem_reg == '0);

endmodule

FILE: rtl/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool kept as a LIFO stack of free block indices.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// shows on granted_address, status and free_count for one cycle with done
// high and must be captured then. An allocate passes through the prep
// (offset), check (and stack read), multiply and add states, and done rises
// as busy falls; an empty pool, a null return or a return outside the pool
// span answers from the check state. A free that reaches the divider goes
// on through the bit-serial divider, which turns the address offset into a
// block index, and then a finish state. Register writes are taken whenever
// busy and start are both low and reload the free stack at once, so the pool
// is full again after any write to a known register index.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [fbpa_pkg::ADDR_W-1:0]       return_address,
    output logic                              done,
    output logic [fbpa_pkg::ADDR_W-1:0]       granted_address,
    output logic [fbpa_pkg::ST_W-1:0]         status,
    output logic [fbpa_pkg::CNT_W-1:0]        free_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]       cfg_data
);
    import fbpa_pkg::*;

    fsm_t              state_reg, state_next;
    logic [ADDR_W-1:0] base_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [CNT_W-1:0]  nblk_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              action_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [SPAN_W-1:0] prod_reg;
    logic              done_reg, done_next;
    logic [ADDR_W-1:0] granted_reg, granted_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  free_reg;

    logic [BS_W-1:0]   bsize;
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  nblk_new;
    logic              cfg_wr;
    logic              cfg_known;
    cfg_idx_t          cfg_sel;
    stack_req_t        stk;
    logic [IDX_W-1:0]  stk_value;
    logic              div_start;
    logic              div_done;
    logic [IDX_W-1:0]  div_q;
    logic              div_exact;

    assign bsize     = eff_bsize(req_reg);
    assign cap       = eff_cap(nblk_reg);
    assign busy      = (state_reg != S_IDLE);
    // a command word has priority over a register write in the same cycle
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_sel   = cfg_idx_t'(cfg_index);
    assign cfg_known = (cfg_sel == CFG_BASE) || (cfg_sel == CFG_BSIZE) || (cfg_sel == CFG_NBLK);
    assign nblk_new  = (cfg_sel == CFG_NBLK) ? cfg_data[CNT_W-1:0] : nblk_reg;

    fbpa_stack u_stack
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (stk),
        .rd_value (stk_value)
    );

    fbpa_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (off_reg[REM_W-1:0]),
        .divisor  (bsize),
        .done     (div_done),
        .quotient (div_q),
        .exact    (div_exact)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        stk          = '0;
        div_start    = 1'b0;
        done_next    = 1'b0;
        granted_next = '0;
        status_next  = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr && cfg_known)
                begin
                    stk.clear  = 1'b1;
                    count_next = eff_cap(nblk_new);
                end
                else if (start)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!action_reg)
                begin
                    if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_EMPTY;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        stk.rd_en   = 1'b1;
                        stk.rd_addr = IDX_W'(count_reg - CNT_W'(1));
                        state_next  = S_MUL;
                    end
                end
                else if (addr_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NULL;
                    state_next  = S_IDLE;
                end
                else if (off_reg >= ADDR_W'(span_reg))
                begin
                    done_next   = 1'b1;
                    status_next = ST_FOREIGN;
                    state_next  = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                done_next    = 1'b1;
                granted_next = base_reg + ADDR_W'(prod_reg);
                state_next   = S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!div_exact)
                begin
                    status_next = ST_FOREIGN;
                end
                else if (count_reg >= cap)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    stk.wr_en   = 1'b1;
                    stk.wr_addr = IDX_W'(count_reg);
                    stk.wr_data = div_q;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= eff_cap(NBLK_RST);
            base_reg  <= BASE_RST;
            req_reg   <= BSIZE_RST;
            nblk_reg  <= NBLK_RST;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_wr)
            begin
                unique case (cfg_sel)
                    CFG_BASE:  base_reg <= cfg_data;
                    CFG_BSIZE: req_reg  <= cfg_data[REQ_W-1:0];
                    CFG_NBLK:  nblk_reg <= cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg <= action;
            addr_reg   <= return_address;
        end
        if (state_reg == S_PREP)
        begin
            off_reg  <= addr_reg - base_reg;
            span_reg <= SPAN_W'(bsize) * SPAN_W'(cap);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= SPAN_W'(stk_value) * SPAN_W'(bsize);
        end
        if (done_next)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            free_reg    <= count_next;
        end
    end

    assign done            = done_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;
    assign free_count      = free_reg;

endmodule

FILE: rtl/fbpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [fbpa_pkg::ADDR_W-1:0]   granted_address,
    input logic [fbpa_pkg::ST_W-1:0]     status,
    input logic [fbpa_pkg::CNT_W-1:0]    free_count
);
    import fbpa_pkg::*;

    // an accepted command always makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command accepted but block not busy");

    // a result word only appears once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // one result word per command, never back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // failed commands grant nothing
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (granted_address == '0))
        else $error("address granted on a failed command");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (free_count <= CNT_W'(MAX_BLOCKS)))
        else $error("free count beyond pool size");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .granted_address (granted_address),
    .status          (status),
    .free_count      (free_count)
);

FILE: tb/fixed_block_pool_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test
// Self-checking bench for the block pool allocator. A directed table of
// allocate/free words and register writes comes first, then random phases
// with random pool geometry and sender bursts. Every result word is checked
// field by field against a typed answer or a behavioral copy of the free stack.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_LIMIT  = 40;
    localparam int SCRIPT_ROWS  = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           st;
        logic [CNT_W-1:0]  cnt;
    } pool_answer_t;

    typedef struct packed {
        logic                 is_write;
        logic                 act;
        logic [CFG_IDX_W-1:0] sel;
        logic [ADDR_W-1:0]    value;
        logic                 typed;
        pool_answer_t         answer;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 action = 1'b0;
    logic [ADDR_W-1:0]    return_address = '0;
    logic                 done;
    logic [ADDR_W-1:0]    granted_address;
    logic [ST_W-1:0]      status;
    logic [CNT_W-1:0]     free_count;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;

    // shadow of the pool registers and free stack
    logic [ADDR_W-1:0] pool_base;
    logic [REQ_W-1:0]  pool_req;
    logic [CNT_W-1:0]  pool_nblk;
    logic [IDX_W-1:0]  free_idx [MAX_BLOCKS];
    int unsigned       free_top;

    pool_answer_t      answers_due [$];
    logic [ADDR_W-1:0] granted_blocks [$];
    int                mismatches = 0;
    int unsigned       cycle_count = 0;
    int unsigned       alloc_pct;

    // directed words; typed answers only where they are obvious
    script_row_t script [SCRIPT_ROWS] = '{
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0,              1'b1,
            '{48'h0,       ST_NULL,     9'd256}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0000, 1'b1,
            '{48'h0,       ST_OVERFLOW, 9'd256}},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'h0,              1'b1,
            '{48'h1_0FF0,  ST_OK,       9'd255}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0FF0, 1'b1,
            '{48'h0,       ST_OK,       9'd256}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0008, 1'b1,
            '{48'h0,       ST_FOREIGN,  9'd256}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0000_FFF0, 1'b1,
            '{48'h0,       ST_FOREIGN,  9'd256}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_1000, 1'b1,
            '{48'h0,       ST_FOREIGN,  9'd256}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'hFFFF_FFFF_FFFF, 1'b1,
            '{48'h0,       ST_FOREIGN,  9'd256}},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'h0,              1'b0, '0},
        // same block returned twice, then once more into a full stack
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0FF0, 1'b0, '0},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0FF0, 1'b0, '0},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0FF0, 1'b0, '0},
        '{1'b1, ACT_ALLOC, CFG_NBLK,  48'h0,              1'b0, '0},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'h0,              1'b1,
            '{48'h1_0000,  ST_OK,       9'd0}},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'h0,              1'b1,
            '{48'h0,       ST_EMPTY,    9'd0}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0010, 1'b1,
            '{48'h0,       ST_FOREIGN,  9'd0}},
        // write to an unused index must not refill the stack
        '{1'b1, ACT_ALLOC, CFG_SPARE, 48'hA5A5_5A5A_FFFF, 1'b0, '0},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'h0,              1'b1,
            '{48'h0,       ST_EMPTY,    9'd0}},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_0000, 1'b1,
            '{48'h0,       ST_OK,       9'd1}},
        '{1'b1, ACT_ALLOC, CFG_NBLK,  48'h0000_0000_01FF, 1'b0, '0},
        '{1'b1, ACT_ALLOC, CFG_BSIZE, 48'h0000_0001_FFFF, 1'b0, '0},
        '{1'b1, ACT_ALLOC, CFG_BASE,  48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'h0,              1'b0, '0},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_01FD_FFFF, 1'b0, '0},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0000_0001_FFFF, 1'b0, '0},
        '{1'b1, ACT_ALLOC, CFG_BSIZE, 48'h0,              1'b0, '0},
        '{1'b1, ACT_ALLOC, CFG_BASE,  48'h0,              1'b0, '0},
        '{1'b0, ACT_ALLOC, CFG_BASE,  48'h0,              1'b0, '0},
        '{1'b0, ACT_FREE,  CFG_BASE,  48'h0,              1'b0, '0}
    };

    fixed_block_pool_allocator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .return_address  (return_address),
        .done            (done),
        .granted_address (granted_address),
        .status          (status),
        .free_count      (free_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [ADDR_W-1:0] any_address();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic longint unsigned pool_block_bytes();
        longint unsigned req;
        req = (pool_req == '0) ? 64'd1 : 64'(pool_req);
        return (req + ALIGNMENT - 1) / ALIGNMENT * ALIGNMENT;
    endfunction

    function automatic int unsigned capacity();
        if (pool_nblk == '0)
            return 1;
        if (pool_nblk > MAX_BLOCKS)
            return MAX_BLOCKS;
        return int'(pool_nblk);
    endfunction

    function automatic void refill_stack();
        for (int i = 0; i < MAX_BLOCKS; i++)
            free_idx[i] = IDX_W'(i);
        free_top = capacity();
    endfunction

    function automatic void load_register(input logic [CFG_IDX_W-1:0] sel,
                                          input logic [ADDR_W-1:0] data);
        case (sel)
            CFG_BASE:  pool_base = data;
            CFG_BSIZE: pool_req  = data[REQ_W-1:0];
            CFG_NBLK:  pool_nblk = data[CNT_W-1:0];
            default:   return;
        endcase
        refill_stack();
    endfunction

    function automatic pool_answer_t next_pool_answer(input logic act,
                                                      input logic [ADDR_W-1:0] addr);
        pool_answer_t      ans;
        longint unsigned   bs;
        longint unsigned   span;
        longint unsigned   offset;
        logic [ADDR_W-1:0] rel;
        ans.addr = '0;
        ans.st   = ST_OK;
        bs       = pool_block_bytes();
        if (act == ACT_ALLOC)
        begin
            if (free_top == 0)
                ans.st = ST_EMPTY;
            else
            begin
                free_top--;
                ans.addr = ADDR_W'(pool_base + free_idx[free_top] * bs);
            end
        end
        else if (addr == '0)
            ans.st = ST_NULL;
        else
        begin
            // offset wraps at the address width
            rel    = addr - pool_base;
            offset = 64'(rel);
            span   = bs * capacity();
            if (offset >= span || offset % bs != 0)
                ans.st = ST_FOREIGN;
            else if (free_top >= capacity())
                ans.st = ST_OVERFLOW;
            else
            begin
                free_idx[free_top] = IDX_W'(offset / bs);
                free_top++;
            end
        end
        ans.cnt = CNT_W'(free_top);
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_word(input logic act, input logic [ADDR_W-1:0] addr,
                             input logic typed, input pool_answer_t typed_answer);
        pool_answer_t predicted;
        @(negedge clk);
        start          <= 1'b1;
        action         <= act;
        return_address <= addr;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predicted = next_pool_answer(act, addr);
        if (act == ACT_ALLOC && predicted.st == ST_OK)
            granted_blocks = {granted_blocks, predicted.addr};
        answers_due = {answers_due, (typed ? typed_answer : predicted)};
        // drop start so the word is not taken again once the block goes idle
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [ADDR_W-1:0] data);
        while (answers_due.size() != 0)
            @(posedge clk);
        idle_cycles(IDX_W + 8);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        load_register(sel, data);
        granted_blocks.delete();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_register(output logic [CFG_IDX_W-1:0] sel,
                                 output logic [ADDR_W-1:0] data);
        logic [ADDR_W-1:0] junk;
        logic [REQ_W-1:0]  req;
        logic [CNT_W-1:0]  nblk;
        junk = any_address();
        case ($urandom_range(0, 9))
            0:
            begin
                sel  = CFG_SPARE;
                data = junk;
            end
            1, 2, 3:
            begin
                sel = CFG_BASE;
                case ($urandom_range(0, 4))
                    0:       data = '0;
                    1:       data = '1;
                    2:       data = junk & ~ADDR_W'(ALIGNMENT - 1);
                    3:       data = junk;
                    default: data = '1 - ADDR_W'($urandom_range(0, 1 << 20));
                endcase
            end
            4, 5, 6:
            begin
                sel = CFG_BSIZE;
                case ($urandom_range(0, 7))
                    0:       req = '0;
                    1:       req = REQ_W'(1);
                    2:       req = REQ_W'(ALIGNMENT);
                    3:       req = REQ_W'(ALIGNMENT + 1);
                    4:       req = REQ_W'(65536);
                    5:       req = '1;
                    6:       req = REQ_W'($urandom_range(1, 64));
                    default: req = REQ_W'($urandom_range(1, 65536));
                endcase
                // upper bits of the data word are don't-care
                data = ($urandom_range(0, 1) != 0) ? {junk[ADDR_W-1:REQ_W], req}
                                                   : ADDR_W'(req);
            end
            default:
            begin
                sel = CFG_NBLK;
                case ($urandom_range(0, 7))
                    0:       nblk = '0;
                    1:       nblk = CNT_W'(1);
                    2, 3:    nblk = CNT_W'($urandom_range(1, 8));
                    4:       nblk = CNT_W'($urandom_range(1, 32));
                    5:       nblk = CNT_W'(MAX_BLOCKS);
                    6:       nblk = CNT_W'($urandom_range(1, MAX_BLOCKS));
                    default: nblk = CNT_W'($urandom_range(MAX_BLOCKS + 1, 511));
                endcase
                data = ($urandom_range(0, 1) != 0) ? {junk[ADDR_W-1:CNT_W], nblk}
                                                   : ADDR_W'(nblk);
            end
        endcase
    endtask

    task automatic pick_word(output logic act, output logic [ADDR_W-1:0] addr);
        longint unsigned bs;
        int unsigned     cap;
        int unsigned     r;
        int unsigned     k;
        bs   = pool_block_bytes();
        cap  = capacity();
        r    = $urandom_range(0, 99);
        act  = ACT_FREE;
        addr = any_address();
        if (r < alloc_pct)
            act = ACT_ALLOC;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55 && granted_blocks.size() != 0)
            begin
                k    = $urandom_range(0, granted_blocks.size() - 1);
                addr = granted_blocks[k];
                // now and then keep it around for a double return
                if ($urandom_range(0, 9) != 0)
                    granted_blocks.delete(k);
            end
            else if (r < 75)
                addr = ADDR_W'(pool_base + $urandom_range(0, cap - 1) * bs);
            else if (r < 80)
                addr = '0;
            else if (r < 87)
                addr = ADDR_W'(pool_base + $urandom_range(0, cap - 1) * bs
                               + $urandom_range(1, int'(bs) - 1));
            else if (r < 94)
                addr = ADDR_W'(pool_base + (cap + $urandom_range(0, 3)) * bs);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pool_answer_t due;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
                report_mismatch("unexpected result, granted_address", 64'(granted_address),
                                64'd0);
            else
            begin
                due = answers_due.pop_front();
                if (granted_address !== due.addr)
                    report_mismatch("granted_address", 64'(granted_address), 64'(due.addr));
                if (status !== due.st)
                    report_mismatch("status", 64'(status), 64'(due.st));
                if (free_count !== due.cnt)
                    report_mismatch("free_count", 64'(free_count), 64'(due.cnt));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic                 act;
        logic [ADDR_W-1:0]    addr;
        logic [CFG_IDX_W-1:0] sel;
        logic [ADDR_W-1:0]    data;
        int unsigned          words_sent;
        int unsigned          gap_max;
        int unsigned          burst_left;

        pool_base = BASE_RST;
        pool_req  = BSIZE_RST;
        pool_nblk = NBLK_RST;
        refill_stack();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            if (script[i].is_write)
                write_reg(script[i].sel, script[i].value);
            else
                send_word(script[i].act, script[i].value, script[i].typed,
                          script[i].answer);
        end

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            repeat ($urandom_range(1, 3))
            begin
                pick_register(sel, data);
                write_reg(sel, data);
            end
            alloc_pct  = $urandom_range(25, 65);
            gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = 0;
            repeat ($urandom_range(20, 150))
            begin
                if (burst_left == 0)
                begin
                    idle_cycles($urandom_range(0, gap_max));
                    burst_left = $urandom_range(1, 20);
                end
                pick_word(act, addr);
                send_word(act, addr, 1'b0, '0);
                burst_left--;
                words_sent++;
            end
        end

        while (answers_due.size() != 0)
            @(posedge clk);
        idle_cycles(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: fixed_block_pool_allocator.f
rtl/fbpa_pkg.sv
rtl/fbpa_stack.sv
rtl/fbpa_divider.sv
rtl/fixed_block_pool_allocator.sv
rtl/fbpa_checker.sv
tb/fixed_block_pool_allocator_test.sv
